### sv/fwh_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the fixed-width histogram engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package fwh_pkg;

    localparam int DEF_NUM_BINS   = 64;
    localparam int DEF_COUNT_BITS = 32;

    localparam int BIN_IDX_W   = 6;
    localparam int NB_W        = 7;
    // Most bins a request can reach: bins_in_use tops out one below 2**NB_W.
    localparam int REACH_BINS  = 2 ** NB_W - 1;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Request types.
    localparam logic [1:0] REQ_ADD      = 2'd0;
    localparam logic [1:0] REQ_READ     = 2'd1;
    localparam logic [1:0] REQ_READ_CLR = 2'd2;

    // Result status codes.
    localparam logic [1:0] RS_COUNTED   = 2'd0;
    localparam logic [1:0] RS_RANGE     = 2'd1;
    localparam logic [1:0] RS_READ      = 2'd2;
    localparam logic [1:0] RS_BAD       = 2'd3;

    // Configuration register indexes.
    localparam logic [1:0] CFG_BIN_START   = 2'd0;
    localparam logic [1:0] CFG_BIN_WIDTH   = 2'd1;
    localparam logic [1:0] CFG_BINS_IN_USE = 2'd2;

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [31:0] sample_value;
        logic [5:0]         bin_index;
    } req_t;

    typedef struct packed {
        logic [31:0] bin_total;
        logic [5:0]  result_bin;
        logic [1:0]  status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_CHECK,
        ST_MEM_RD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic check;
        logic mem_rd;
        logic finish;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic div_last;
        logic hit;
        logic clr_last;
        logic out_free;
    } sts_t;

endpackage

### sv/fixed_width_histogram_top.sv
`timescale 1ns / 1ps
// Top level of the fixed-width histogram engine: joins controller and datapath.
// Depends on fwh_pkg, fwh_ctrl and fwh_datapath.
//
// Each request gives exactly one result. An add-sample request goes from
// acceptance to the next acceptance through taking the request, 32 steps of
// the one-bit-per-cycle restoring divider that finds the bin, the range
// check, the registered bin memory read and a last step that writes the bin
// back and loads the result register. Read and read-and-clear requests skip
// the divider. A request that counts nothing or reads no bin skips the memory
// read. The last step waits for as long as an earlier result is still stalled
// in the output register. A result waits in the output register while the
// next request is accepted and worked on. After reset the engine stalls its
// input for a clearing pass over min(NUM_BINS, 127) bins, one bin per cycle;
// configuration writes are taken at any time and must only be made while
// idle.
module fixed_width_histogram_top #(
    parameter int NUM_BINS   = fwh_pkg::DEF_NUM_BINS,
    parameter int COUNT_BITS = fwh_pkg::DEF_COUNT_BITS
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  fwh_pkg::req_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output fwh_pkg::rsp_t   out_data,
    input  logic            cfg_wr_en,
    input  logic [1:0]      cfg_index,
    input  logic [31:0]     cfg_data
);
    import fwh_pkg::*;

    cmd_t cmd;
    sts_t sts;

    fwh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    fwh_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .in_data   (in_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // After a request is taken the engine is busy until its result is loaded.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input not stalled after a request was accepted");

    a_stall_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (in_stall && !cmd.finish))
        else $error("request taken or result loaded during clearing pass");

    a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid)
        else $error("finished result did not appear at the output");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(cmd.finish))
        else $error("result appeared without a finished request");

endmodule

### sv/fwh_ctrl.sv
`timescale 1ns / 1ps
// Sequencer of the histogram engine: after the clearing pass that follows reset,
// walks each request through divide (add-sample only), check, bin read (on a hit) and result. Depends on fwh_pkg.
module fwh_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [1:0]          req_type,
    output logic                in_stall,
    input  fwh_pkg::sts_t       sts,
    output fwh_pkg::cmd_t       cmd
);
    import fwh_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == REQ_ADD) ? ST_DIV : ST_CHECK;
                end
            end
            ST_DIV:
            begin
                if (sts.div_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = sts.hit ? ST_MEM_RD : ST_FINISH;
            end
            ST_MEM_RD:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall     = (state_reg != ST_IDLE);
        cmd.load     = (state_reg == ST_IDLE) && in_valid;
        cmd.div_step = (state_reg == ST_DIV);
        cmd.check    = (state_reg == ST_CHECK);
        cmd.mem_rd   = (state_reg == ST_MEM_RD);
        // The result is only loaded once the output register can take it.
        cmd.finish   = (state_reg == ST_FINISH) && sts.out_free;
        cmd.clear    = (state_reg == ST_CLEAR);
    end

endmodule

### sv/fwh_datapath.sv
`timescale 1ns / 1ps
// Datapath of the histogram engine: configuration registers, the restoring
// divider, the bin counter memory and the result register. Depends on fwh_pkg.
module fwh_datapath #(
    parameter int NUM_BINS   = fwh_pkg::DEF_NUM_BINS,
    parameter int COUNT_BITS = fwh_pkg::DEF_COUNT_BITS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  fwh_pkg::cmd_t       cmd,
    output fwh_pkg::sts_t       sts,
    input  fwh_pkg::req_t       in_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    output logic                out_valid,
    input  logic                out_stall,
    output fwh_pkg::rsp_t       out_data
);
    import fwh_pkg::*;

    localparam int IDX_W     = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int CLR_DEPTH = (NUM_BINS < REACH_BINS) ? NUM_BINS : REACH_BINS;
    localparam logic [NB_W-1:0]  NB_CAP   = NB_W'(CLR_DEPTH);
    localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(CLR_DEPTH - 1);

    // Configuration.
    logic signed [31:0] bin_start_reg;
    logic [15:0]        bin_width_reg;
    logic [NB_W-1:0]    bins_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_start_reg   <= '0;
            bin_width_reg   <= 16'd1;
            bins_in_use_reg <= 7'd64;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_BIN_START:   bin_start_reg   <= cfg_data;
                CFG_BIN_WIDTH:   bin_width_reg   <= cfg_data[15:0];
                CFG_BINS_IN_USE: bins_in_use_reg <= cfg_data[NB_W-1:0];
                default:         ;
            endcase
        end
    end

    logic [NB_W-1:0] active_bins;
    assign active_bins = (bins_in_use_reg > NB_CAP) ? NB_CAP : bins_in_use_reg;

    // Request capture and offset; the offset is exact in 33 bits.
    logic signed [32:0] offset;
    assign offset = {in_data.sample_value[31], in_data.sample_value}
                  - {bin_start_reg[31], bin_start_reg};

    logic [1:0]           req_type_reg;
    logic [BIN_IDX_W-1:0] req_idx_reg;
    logic                 off_neg_reg;
    logic [31:0]          quo_reg;
    logic [15:0]          rem_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;

    // One quotient bit per step.
    logic [16:0] rem_shift;
    logic [16:0] rem_diff;
    logic        q_bit;
    assign rem_shift = {rem_reg, quo_reg[31]};
    assign rem_diff  = rem_shift - {1'b0, bin_width_reg};
    assign q_bit     = (rem_shift >= {1'b0, bin_width_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= in_data.req_type;
            req_idx_reg  <= in_data.bin_index;
            off_neg_reg  <= offset[32];
            quo_reg      <= offset[31:0];
            rem_reg      <= '0;
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[30:0], q_bit};
            rem_reg <= q_bit ? rem_diff[15:0] : rem_shift[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end
    end

    // Range and index check.
    logic                 hit;
    logic [1:0]           stat;
    logic [BIN_IDX_W-1:0] rbin;
    logic [IDX_W-1:0]     addr;

    always_comb
    begin
        hit  = 1'b0;
        stat = RS_BAD;
        rbin = req_idx_reg;
        addr = IDX_W'(req_idx_reg);
        unique case (req_type_reg)
            REQ_ADD:
            begin
                hit  = !off_neg_reg && (bin_width_reg != '0) && (active_bins != '0)
                    && (quo_reg < {{(32 - NB_W){1'b0}}, active_bins});
                stat = hit ? RS_COUNTED : RS_RANGE;
                rbin = hit ? quo_reg[BIN_IDX_W-1:0] : '0;
                addr = IDX_W'(quo_reg);
            end
            REQ_READ, REQ_READ_CLR:
            begin
                hit  = ({1'b0, req_idx_reg} < active_bins);
                stat = hit ? RS_READ : RS_BAD;
            end
            default:
            begin
                hit  = 1'b0;
                stat = RS_BAD;
            end
        endcase
    end

    logic                 hit_reg;
    logic [1:0]           stat_reg;
    logic [BIN_IDX_W-1:0] rbin_reg;
    logic [IDX_W-1:0]     addr_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            hit_reg  <= hit;
            stat_reg <= stat;
            rbin_reg <= rbin;
            addr_reg <= addr;
        end
    end

    // Clearing pass over every reachable bin after reset.
    logic [IDX_W-1:0] clr_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + IDX_W'(1);
        end
    end

    // Bin counter memory.
    logic [COUNT_BITS-1:0] mem [NUM_BINS];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;

    assign cnt_inc = (&rd_data_reg) ? rd_data_reg : rd_data_reg + COUNT_BITS'(1);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_cnt_reg;
        end
        else if (cmd.finish && hit_reg)
        begin
            mem_we    = (req_type_reg == REQ_ADD) || (req_type_reg == REQ_READ_CLR);
            mem_wdata = (req_type_reg == REQ_ADD) ? cnt_inc : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.mem_rd)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    // Result register.
    logic [COUNT_BITS-1:0] total;
    logic [63:0]           total_wide;
    logic                  out_valid_reg;
    rsp_t                  out_data_reg;

    assign total      = !hit_reg ? '0
                      : (req_type_reg == REQ_ADD) ? cnt_inc : rd_data_reg;
    assign total_wide = 64'(total);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.bin_total  <= total_wide[31:0];
            out_data_reg.result_bin <= rbin_reg;
            out_data_reg.status     <= stat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sts.div_last = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.hit      = hit;
    assign sts.clr_last = (clr_cnt_reg == CLR_LAST);
    assign sts.out_free = !out_valid_reg || !out_stall;

endmodule
